// ===== rtl/fga_pkg.sv =====
// Package for the frame gap accounting filter: field widths, frame class codes
// and the input and result item structs shared by the modules.
// No dependencies.
package fga_pkg;

    localparam int ID_BITS     = 36;
    localparam int COUNT_BITS  = 48;
    localparam int EVENT_BITS  = 12;
    localparam int MARKER_BITS = ID_BITS + 2;

    // tag in the top bits of the first lost-run marker word
    localparam logic [1:0] MARKER_TAG = 2'b10;

    // frame class codes; unknown is only held as the previous class
    typedef enum logic [2:0] {
        CLS_SOME_DATA = 3'd0,
        CLS_ZERO_DATA = 3'd1,
        CLS_SOME_LOST = 3'd2,
        CLS_ALL_LOST  = 3'd3,
        CLS_UNKNOWN   = 3'd4
    } fga_cls_t;

    // one frame descriptor
    typedef struct packed {
        logic                  step_start;
        logic                  step_closing;
        logic [ID_BITS-1:0]    frame_id;
        logic [EVENT_BITS-1:0] event_count;
        logic                  frame_lost;
    } fga_in_t;

    // one result per frame
    typedef struct packed {
        logic [1:0]             frame_class;
        logic                   keep_frame;
        logic                   emit_lost_marker;
        logic [MARKER_BITS-1:0] lost_marker_word;
        logic                   id_reversal;
        logic [COUNT_BITS-1:0]  step_all_frames;
        logic [COUNT_BITS-1:0]  step_lost_all;
        logic [COUNT_BITS-1:0]  step_lost_some;
        logic [COUNT_BITS-1:0]  step_events;
        logic [EVENT_BITS-1:0]  step_max_events;
    } fga_out_t;

endpackage

// ===== rtl/frame_gap_accounting_filter_top.sv =====
// Top level of the frame gap accounting filter: input register, accounting
// stage and result register. Depends on fga_pkg, fga_in_reg, fga_acct, fga_out_reg.
//
// Accepts one frame descriptor per clock cycle while the result side is not
// stalled and returns exactly one result per frame, in order; the input
// register and the result register lie between the two. The per-frame state
// (expected next id, previous class and the five step counters) is read and
// rewritten as a frame moves from the input register to the result register.
// A frame with step_start set clears the step counters before it is counted.
// A gap in frame ids counts the skipped frames as fully lost in both modes; in
// standard mode it also raises emit_lost_marker with the first marker word.
// Counters saturate at all ones. standard_mode resets to 1; the user must write it
// through cfg_wr_en/cfg_wr_data only while no frame is in flight (not enforced).
module frame_gap_accounting_filter_top (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic              cfg_wr_data,
    input  logic              s_valid,
    output logic              s_ready,
    input  fga_pkg::fga_in_t   s_item,
    output logic              m_valid,
    input  logic              m_ready,
    output fga_pkg::fga_out_t  m_item
);

    logic              item_valid;
    logic              advance;
    logic              can_load;
    fga_pkg::fga_in_t  item;
    fga_pkg::fga_out_t result;

    // a frame moves on when the result register has room
    assign advance = item_valid && can_load;

    fga_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .item_valid (item_valid),
        .item_take  (advance),
        .item       (item)
    );

    fga_acct u_acct (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .advance     (advance),
        .item        (item),
        .result      (result)
    );

    fga_out_reg u_out_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (advance),
        .can_load (can_load),
        .result   (result),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_item   (m_item)
    );

endmodule

// ===== rtl/fga_in_reg.sv =====
// Input register of the frame gap accounting filter: holds one frame descriptor
// until the accounting stage takes it. Depends on fga_pkg.
module fga_in_reg (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  fga_pkg::fga_in_t s_item,
    output logic            item_valid,
    input  logic            item_take,
    output fga_pkg::fga_in_t item
);

    logic             valid_reg;
    logic             valid_next;
    fga_pkg::fga_in_t item_reg;

    // free slot, or the held item leaves in this cycle
    assign s_ready = !valid_reg || item_take;

    always_comb begin
        valid_next = valid_reg;
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
        end else if (item_take) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // payload, loaded on each input transfer
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ===== rtl/fga_acct.sv =====
// Accounting stage of the frame gap accounting filter: per-step state, gap and
// reversal detection, classification, suppression and saturating counters.
// Depends on fga_pkg.
module fga_acct (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wr_en,
    input  logic             cfg_wr_data,
    input  logic             advance,
    input  fga_pkg::fga_in_t  item,
    output fga_pkg::fga_out_t result
);

    localparam int CB = fga_pkg::COUNT_BITS;
    localparam int IB = fga_pkg::ID_BITS;
    localparam int EB = fga_pkg::EVENT_BITS;

    logic               mode_reg;
    logic [IB:0]        prev_p1_reg;
    logic [IB:0]        prev_p1_next;
    fga_pkg::fga_cls_t  prev_cls_reg;
    fga_pkg::fga_cls_t  prev_cls_next;
    logic [CB-1:0]      all_reg;
    logic [CB-1:0]      all_next;
    logic [CB-1:0]      lost_all_reg;
    logic [CB-1:0]      lost_all_next;
    logic [CB-1:0]      lost_some_reg;
    logic [CB-1:0]      lost_some_next;
    logic [CB-1:0]      events_reg;
    logic [CB-1:0]      events_next;
    logic [EB-1:0]      max_reg;
    logic [EB-1:0]      max_next;

    logic [IB:0]        eff_prev;
    logic [IB:0]        fid_ext;
    logic               reversal;
    logic               gap;
    logic [IB-1:0]      skipped;
    logic [CB-1:0]      all_base;
    logic [CB-1:0]      lost_all_base;
    logic [CB-1:0]      lost_some_base;
    logic [CB-1:0]      events_base;
    logic [EB-1:0]      max_base;
    logic               zero_ev;
    logic               lost_all_inc;
    logic               lost_some_inc;
    logic [CB:0]        all_sum;
    logic [CB:0]        lost_all_sum;
    logic [CB:0]        lost_some_sum;
    logic [CB:0]        events_sum;
    fga_pkg::fga_cls_t  cls;
    fga_pkg::fga_cls_t  cls_before;
    logic [2:0]         cls_bits;
    logic               suppress;
    logic               emit;

    // mode register; the user must write it only while idle, not enforced here
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= 1'b1;
        end else if (cfg_wr_en) begin
            mode_reg <= cfg_wr_data;
        end
    end

    // step start restarts the per-step view before the frame is handled
    always_comb begin
        fid_ext        = {1'b0, item.frame_id};
        eff_prev       = item.step_start ? fid_ext : prev_p1_reg;
        all_base       = item.step_start ? '0 : all_reg;
        lost_all_base  = item.step_start ? '0 : lost_all_reg;
        lost_some_base = item.step_start ? '0 : lost_some_reg;
        events_base    = item.step_start ? '0 : events_reg;
        max_base       = item.step_start ? '0 : max_reg;
    end

    // gap and reversal against the expected next id
    always_comb begin
        reversal = fid_ext < eff_prev;
        gap      = fid_ext > eff_prev;
        skipped  = gap ? (item.frame_id - eff_prev[IB-1:0]) : '0;
        emit     = mode_reg && gap;
    end

    // saturating counters; skipped frames add to the frame and all-lost counts
    always_comb begin
        zero_ev       = (item.event_count == '0);
        lost_all_inc  = item.frame_lost && zero_ev;
        lost_some_inc = item.frame_lost && !zero_ev;
        all_sum       = {1'b0, all_base} + {{(CB+1-IB){1'b0}}, skipped}
                        + {{CB{1'b0}}, 1'b1};
        lost_all_sum  = {1'b0, lost_all_base} + {{(CB+1-IB){1'b0}}, skipped}
                        + {{CB{1'b0}}, lost_all_inc};
        lost_some_sum = {1'b0, lost_some_base} + {{CB{1'b0}}, lost_some_inc};
        events_sum    = {1'b0, events_base} + {{(CB+1-EB){1'b0}}, item.event_count};
        all_next       = all_sum[CB]       ? '1 : all_sum[CB-1:0];
        lost_all_next  = lost_all_sum[CB]  ? '1 : lost_all_sum[CB-1:0];
        lost_some_next = lost_some_sum[CB] ? '1 : lost_some_sum[CB-1:0];
        events_next    = events_sum[CB]    ? '1 : events_sum[CB-1:0];
        max_next       = (item.event_count > max_base) ? item.event_count : max_base;
        prev_p1_next   = fid_ext + {{IB{1'b0}}, 1'b1};
    end

    // classification and repeat suppression
    always_comb begin
        if (item.frame_lost) begin
            cls = zero_ev ? fga_pkg::CLS_ALL_LOST : fga_pkg::CLS_SOME_LOST;
        end else begin
            cls = zero_ev ? fga_pkg::CLS_ZERO_DATA : fga_pkg::CLS_SOME_DATA;
        end
        if (gap) begin
            cls_before = fga_pkg::CLS_ALL_LOST;
        end else if (item.step_start) begin
            cls_before = fga_pkg::CLS_UNKNOWN;
        end else begin
            cls_before = prev_cls_reg;
        end
        suppress = !item.step_closing && (cls == cls_before) &&
                   ((cls == fga_pkg::CLS_ZERO_DATA) || (cls == fga_pkg::CLS_ALL_LOST));
        prev_cls_next = suppress ? cls_before : cls;
        cls_bits      = cls;
    end

    // result fields
    always_comb begin
        result.frame_class      = cls_bits[1:0];
        result.keep_frame       = mode_reg && !suppress;
        result.emit_lost_marker = emit;
        result.lost_marker_word = emit ? {fga_pkg::MARKER_TAG, eff_prev[IB-1:0]} : '0;
        result.id_reversal      = reversal;
        result.step_all_frames  = all_next;
        result.step_lost_all    = lost_all_next;
        result.step_lost_some   = lost_some_next;
        result.step_events      = events_next;
        result.step_max_events  = max_next;
    end

    // per-step state, updated as each frame moves to the result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_p1_reg   <= '0;
            prev_cls_reg  <= fga_pkg::CLS_UNKNOWN;
            all_reg       <= '0;
            lost_all_reg  <= '0;
            lost_some_reg <= '0;
            events_reg    <= '0;
            max_reg       <= '0;
        end else if (advance) begin
            prev_p1_reg   <= prev_p1_next;
            prev_cls_reg  <= prev_cls_next;
            all_reg       <= all_next;
            lost_all_reg  <= lost_all_next;
            lost_some_reg <= lost_some_next;
            events_reg    <= events_next;
            max_reg       <= max_next;
        end
    end

`ifndef SYNTHESIS
    // calibration mode never writes frames or markers
    a_calib_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && !mode_reg |-> !result.keep_frame && !result.emit_lost_marker)
        else $error("frame or marker written in calibration mode");

    // expected next id follows the last frame transferred
    a_prev_id: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> prev_p1_reg == {1'b0, $past(item.frame_id)} + {{IB{1'b0}}, 1'b1})
        else $error("previous id not tracking frame id");

    // frame count grows within a step until it saturates
    a_all_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && !item.step_start |=> (all_reg > $past(all_reg)) || (all_reg == '1))
        else $error("frame count did not advance");

    // maximum covers the last frame's event count
    a_max_covers: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> max_reg >= $past(item.event_count))
        else $error("max event count below a seen frame");
`endif

endmodule

// ===== rtl/fga_out_reg.sv =====
// Result register of the frame gap accounting filter: holds one result until
// the downstream side takes it. Depends on fga_pkg.
module fga_out_reg (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              load,
    output logic              can_load,
    input  fga_pkg::fga_out_t  result,
    output logic              m_valid,
    input  logic              m_ready,
    output fga_pkg::fga_out_t  m_item
);

    logic              valid_reg;
    logic              valid_next;
    fga_pkg::fga_out_t item_reg;

    // empty, or the held result leaves in this cycle
    assign can_load = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // payload, loaded as each frame finishes
    always_ff @(posedge aclk) begin
        if (load) begin
            item_reg <= result;
        end
    end

    assign m_valid = valid_reg;
    assign m_item  = item_reg;

endmodule

// ===== verif/frame_gap_accounting_filter_top_tb.sv =====
// Self-checking testbench for frame_gap_accounting_filter_top: drives frame descriptors with
// random idle gaps, predicts every result in a scoreboard class and compares them in order.
// Depends on fga_pkg and frame_gap_accounting_filter_top.
module frame_gap_accounting_filter_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fga_pkg::*;

    localparam logic [ID_BITS-1:0] ID_TOP = '1;

    logic     aclk;
    logic     aresetn     = 1'b0;
    logic     cfg_wr_en   = 1'b0;
    logic     cfg_wr_data = 1'b0;
    logic     s_valid     = 1'b0;
    logic     s_ready;
    fga_in_t  s_item      = '0;
    logic     m_valid;
    logic     m_ready     = 1'b0;
    fga_out_t m_item;

    // no idle cycles on either side while set
    bit quiet = 1'b0;

    // tracks step accounting and holds the results still owed by the block
    class frame_account_checker;
        bit                    std_mode;
        logic [ID_BITS:0]      next_id;
        fga_cls_t              last_class;
        logic [COUNT_BITS-1:0] n_frames, n_lost_all, n_lost_some, n_events;
        logic [EVENT_BITS-1:0] peak_events;
        fga_out_t              pending[$];
        int errors, checked, steps, gaps, reversals, dropped, markers;

        function new();
            std_mode    = 1'b1;
            next_id     = '0;
            last_class  = CLS_UNKNOWN;
            n_frames    = '0;
            n_lost_all  = '0;
            n_lost_some = '0;
            n_events    = '0;
            peak_events = '0;
        endfunction

        function logic [COUNT_BITS-1:0] sat_add(logic [COUNT_BITS-1:0] a, logic [ID_BITS:0] b);
            logic [COUNT_BITS:0] s;
            s = a + b;
            return s[COUNT_BITS] ? '1 : s[COUNT_BITS-1:0];
        endfunction

        // work out the result for one accepted frame and queue it
        function void account_frame(fga_in_t f);
            fga_out_t         e;
            fga_cls_t         cls;
            logic [ID_BITS:0] skip;
            e = '0;
            if (f.step_start) begin
                n_frames    = '0;
                n_lost_all  = '0;
                n_lost_some = '0;
                n_events    = '0;
                peak_events = '0;
                next_id     = f.frame_id;
                last_class  = CLS_UNKNOWN;
                steps++;
            end

            // id reversal or gap of skipped frames
            if (f.frame_id < next_id) begin
                e.id_reversal = 1'b1;
                reversals++;
            end else if (f.frame_id != next_id) begin
                skip       = f.frame_id - next_id;
                n_frames   = sat_add(n_frames, skip);
                n_lost_all = sat_add(n_lost_all, skip);
                if (std_mode) begin
                    e.emit_lost_marker = 1'b1;
                    e.lost_marker_word = {MARKER_TAG, next_id[ID_BITS-1:0]};
                    markers++;
                end
                last_class = CLS_ALL_LOST;
                gaps++;
            end
            next_id = f.frame_id + 1'b1;

            // step counters
            n_events = sat_add(n_events, f.event_count);
            if (f.event_count > peak_events)
                peak_events = f.event_count;
            if (f.frame_lost) begin
                if (f.event_count == 0)
                    n_lost_all = sat_add(n_lost_all, 1);
                else
                    n_lost_some = sat_add(n_lost_some, 1);
            end
            n_frames = sat_add(n_frames, 1);

            // classify and suppress repeats of empty frames
            if (f.frame_lost)
                cls = (f.event_count == 0) ? CLS_ALL_LOST : CLS_SOME_LOST;
            else
                cls = (f.event_count == 0) ? CLS_ZERO_DATA : CLS_SOME_DATA;
            if (!f.step_closing && cls == last_class &&
                (cls == CLS_ZERO_DATA || cls == CLS_ALL_LOST)) begin
                e.keep_frame = 1'b0;
                dropped++;
            end else begin
                last_class   = cls;
                e.keep_frame = std_mode;
            end

            e.frame_class     = 2'(cls);
            e.step_all_frames = n_frames;
            e.step_lost_all   = n_lost_all;
            e.step_lost_some  = n_lost_some;
            e.step_events     = n_events;
            e.step_max_events = peak_events;
            pending.push_back(e);
        endfunction

        task report(string msg);
            errors++;
            if (errors <= 40)
                $display("mismatch: %s", msg);
        endtask

        task compare(string name, logic [63:0] got, logic [63:0] want);
            if (got !== want)
                report($sformatf("result %0d %s got %0h expected %0h", checked, name, got, want));
        endtask

        // compare one result transfer with the oldest queued prediction
        task check_report(fga_out_t r);
            fga_out_t e;
            if (pending.size() == 0) begin
                report("result transfer with no frame outstanding");
                return;
            end
            e = pending.pop_front();
            checked++;
            compare("frame_class", 64'(r.frame_class), 64'(e.frame_class));
            compare("keep_frame", 64'(r.keep_frame), 64'(e.keep_frame));
            compare("emit_lost_marker", 64'(r.emit_lost_marker), 64'(e.emit_lost_marker));
            compare("lost_marker_word", 64'(r.lost_marker_word), 64'(e.lost_marker_word));
            compare("id_reversal", 64'(r.id_reversal), 64'(e.id_reversal));
            compare("step_all_frames", 64'(r.step_all_frames), 64'(e.step_all_frames));
            compare("step_lost_all", 64'(r.step_lost_all), 64'(e.step_lost_all));
            compare("step_lost_some", 64'(r.step_lost_some), 64'(e.step_lost_some));
            compare("step_events", 64'(r.step_events), 64'(e.step_events));
            compare("step_max_events", 64'(r.step_max_events), 64'(e.step_max_events));
        endtask
    endclass

    frame_account_checker board = new();

    frame_gap_accounting_filter_top i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_item      (s_item),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_item      (m_item)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // run limit
    initial begin
        #(20_000_000);
        $display("simulation failed");
        $finish;
    end

    // idle length: mostly none or short, now and then long
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // result side backpressure
    initial begin
        int stall;
        forever begin
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
            stall = quiet ? 0 : gap_len();
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
        end
    end

    // result monitor
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            board.check_report(m_item);
    end

    // one input transfer, with an optional idle gap in front
    task automatic send_frame(input fga_in_t f);
        int gap;
        gap = quiet ? 0 : gap_len();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= f;
        do @(posedge aclk); while (!s_ready);
        board.account_frame(f);
    endtask

    task automatic send_desc(input bit start, input bit closing, input logic [ID_BITS-1:0] id,
                             input logic [EVENT_BITS-1:0] ev, input bit lost);
        fga_in_t f;
        f.step_start   = start;
        f.step_closing = closing;
        f.frame_id     = id;
        f.event_count  = ev;
        f.frame_lost   = lost;
        send_frame(f);
    endtask

    // hold the sender off until every outstanding result has come back
    task automatic drain();
        s_valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge aclk);
        repeat (6) @(posedge aclk);
    endtask

    task automatic write_mode(input bit m);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= m;
        @(posedge aclk);
        board.std_mode = m;
        cfg_wr_en <= 1'b0;
    endtask

    // random steps: mostly consecutive ids with some gaps, reversals and broken steps
    task automatic run_random_phase(input int budget);
        int                    sent, len, k, r, i;
        logic [63:0]           w;
        logic [ID_BITS-1:0]    id;
        logic [EVENT_BITS-1:0] ev;
        fga_in_t               f;
        sent = 0;
        while (sent < budget) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
            k   = $urandom_range(0, 3);
            w   = {$urandom(), $urandom()};
            r   = $urandom_range(0, 9);
            if (r < 4)      id = w[ID_BITS-1:0];
            else if (r < 7) id = $urandom_range(0, 1000);
            else if (r < 9) id = ID_TOP - $urandom_range(0, 50);
            else            id = '0;
            for (i = 0; i < len; i++) begin
                if (i > 0) begin
                    w = {$urandom(), $urandom()};
                    r = $urandom_range(0, 99);
                    if (r < 70)      id = id + 1'b1;
                    else if (r < 78) id = id + 1'b1 + $urandom_range(1, 4);
                    else if (r < 83) id = id + 1'b1 + $urandom_range(5, 1000);
                    else if (r < 86) id = w[ID_BITS-1:0];
                    else if (r < 94) id = id - $urandom_range(0, 3);
                    else             id = id + 1'b1 + w[ID_BITS-1:0] % 64'd100000;
                end
                r = $urandom_range(0, 99);
                w = {$urandom(), $urandom()};
                if (r < 35)      ev = '0;
                else if (r < 50) ev = w[EVENT_BITS-1:0];
                else if (r < 58) ev = '1;
                else             ev = $urandom_range(1, 20);
                f.step_start   = (i == 0) ? ($urandom_range(0, 9) != 0)
                                          : ($urandom_range(0, 49) == 0);
                f.step_closing = (i >= len - k) || ($urandom_range(0, 29) == 0);
                f.frame_id     = id;
                f.event_count  = ev;
                f.frame_lost   = ($urandom_range(0, 3) == 0);
                send_frame(f);
                sent++;
            end
        end
    endtask

    initial begin
        int ph;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed frames in standard mode
        write_mode(1'b1);
        send_desc(1, 0, 0, 0, 0);                       // zero data opens the step
        send_desc(0, 0, 1, 0, 0);                       // repeated zero data dropped
        send_desc(0, 1, 1, 0, 0);                       // reversal, closing keeps it
        send_desc(0, 0, 5, '1, 1);                      // gap with marker, some lost
        send_desc(0, 0, 6, 0, 1);                       // all lost
        send_desc(0, 0, 7, 0, 1);                       // repeated all lost dropped
        send_desc(0, 0, 10, 0, 1);                      // gap then all lost dropped
        send_desc(0, 1, 11, 0, 1);                      // closing all lost kept
        send_desc(0, 0, 3, 12'hAAA, 0);                 // reversal
        send_desc(0, 0, 4, 12'h555, 0);
        send_desc(1, 0, ID_TOP - 1, 12'h001, 0);        // step at the top of the id range
        send_desc(0, 0, ID_TOP, 12'h800, 1);
        send_desc(0, 0, 0, 0, 0);                       // reversal past the top id
        send_desc(1, 1, 0, 0, 1);
        send_desc(0, 0, ID_TOP, '1, 0);                 // wide gap up to the top id
        send_desc(1, 0, 36'h555555555, 0, 0);
        send_desc(0, 0, 36'hAAAAAAAAA, 1, 0);

        // directed frames in calibration mode
        write_mode(1'b0);
        send_desc(1, 0, 100, 0, 0);
        send_desc(0, 0, 101, 0, 0);
        send_desc(0, 0, 150, 7, 1);                     // gap, no marker
        send_desc(0, 0, 150, 0, 1);
        send_desc(0, 1, 151, 0, 1);

        // random phases with alternating mode, two of them without idling
        for (ph = 0; ph < 8; ph++) begin
            write_mode(ph[0]);
            quiet = (ph == 2 || ph == 5);
            run_random_phase(250);
        end
        quiet = 1'b0;
        drain();

        $display("checked %0d results over %0d steps in both modes", board.checked, board.steps);
        $display("seen %0d id gaps (%0d markers), %0d reversals, %0d dropped repeats",
                 board.gaps, board.markers, board.reversals, board.dropped);
        if (board.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
